>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on the rising edge of clk and
// are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/fdhc_pkg.sv
package fdhc_pkg;

  // Field widths of the item channels
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int CHIDX_W  = 6;
  localparam int WORD_W   = 16;
  localparam int TALLY_W  = 32;
  localparam int HIT_W    = 32;

  // Width of a counter index (covers up to 256 counters)
  localparam int CTR_IDX_W = 8;

  // Position of the channel byte within an event
  localparam int CHANNEL_BYTE = 5;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Request into the counter RAM, issued with an accepted item
  typedef struct packed {
    logic                 rd_en;
    logic                 bump_en;
    logic                 clr_en;
    logic [CTR_IDX_W-1:0] index;
  } ctr_req_t;

endpackage

>>> rtl/fdhc_if.sv
// Input item channel
interface fdhc_in_if import fdhc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   data_byte;
  logic [CHIDX_W-1:0]  channel_index;

  modport source (output valid, action, data_byte, channel_index, input ready);
  modport sink   (input valid, action, data_byte, channel_index, output ready);
endinterface

// Result item channel
interface fdhc_out_if import fdhc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [WORD_W-1:0]  frame_command;
  logic [WORD_W-1:0]  payload_len;
  logic [HIT_W-1:0]   hit_count;
  logic [TALLY_W-1:0] event_frames_seen;

  modport source (output valid, result_kind, frame_command, payload_len, hit_count,
                  event_frames_seen, input ready);
  modport sink   (input valid, result_kind, frame_command, payload_len, hit_count,
                  event_frames_seen, output ready);
endinterface

>>> rtl/fdhc_ctr_ram.sv
`include "assert_macros.svh"

// Hit counter RAM: one read port, one write port; read data appears in the cycle after the request.
// A bump reads the entry in the issue cycle and writes back the saturated
// increment in the next. Per-entry valid bits give an instant clear.
module fdhc_ctr_ram import fdhc_pkg::*; #(
  parameter int NUM = 64,
  parameter int CW  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctr_req_t      req,
  output logic [CW-1:0] rd_value
);

  localparam int AW = (NUM > 1) ? $clog2(NUM) : 1;

  logic [CW-1:0]  mem [NUM];
  logic [CW-1:0]  rdata_r;
  logic [NUM-1:0] valid_r;
  logic           s1_bump_r;
  logic [AW-1:0]  s1_addr_r;
  logic           fwd_hit_r;
  logic [CW-1:0]  fwd_data_r;
  logic [AW-1:0]  raddr;
  logic           issue;
  logic [CW-1:0]  old_val;
  logic [CW-1:0]  wdata;

  assign raddr = req.index[AW-1:0];
  assign issue = req.rd_en || req.bump_en;

  // Value of the entry as of the issue cycle: forwarded write, else RAM unless cleared
  assign old_val  = fwd_hit_r ? fwd_data_r : (valid_r[s1_addr_r] ? rdata_r : '0);
  assign wdata    = (old_val == '1) ? old_val : old_val + CW'(1);
  assign rd_value = old_val;

  // Storage
  always_ff @(posedge clk) begin
    if (s1_bump_r) begin
      mem[s1_addr_r] <= wdata;
    end
    if (issue) begin
      rdata_r    <= mem[raddr];
      fwd_data_r <= wdata;
      s1_addr_r  <= raddr;
    end
  end

  // Control: write strobe, valid bits, forward flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_bump_r <= 1'b0;
      valid_r   <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_bump_r <= req.bump_en;
      // a clear arrives after the pending write in item order, so it wins
      if (req.clr_en) begin
        valid_r <= '0;
      end else if (s1_bump_r) begin
        valid_r[s1_addr_r] <= 1'b1;
      end
      if (issue) begin
        fwd_hit_r <= s1_bump_r && (s1_addr_r == raddr);
      end
    end
  end

  // Events are at least six bytes long, so bumps never issue back to back
  `ASSERT_SAME(a_bump_gap, s1_bump_r, !req.bump_en)
  `ASSERT_NEXT(a_clr_empty, req.clr_en, valid_r == '0)
  `ASSERT_NEXT(a_wr_valid, s1_bump_r && !req.clr_en, valid_r[$past(s1_addr_r)])

endmodule

>>> rtl/frame_deframer_channel_hit_counter.sv
// Channel   Dir  Handshake        Carries
// in_ch     in   valid/ready      action, data_byte, channel_index
// out_ch    out  valid/ready      result_kind, frame_command, payload_len,
//                                 hit_count, event_frames_seen
// cfg_*     in   APB write/read   own_address (0x0), event_list_command (0x4)
//
// One item per cycle while in_ch.ready is high. A result passes from its accepted item
// through the RAM stage, which waits on the counter RAM read, to the output register.
// A counter bump is a read-modify-write on the RAM port: a read when issued, then the write-back.
// Synchronous active-low reset; counters clear through valid bits, no sweep.
// in_ch.ready drops only while both the RAM stage and the output register hold
// results and out_ch.ready is low.
`include "assert_macros.svh"

module frame_deframer_channel_hit_counter import fdhc_pkg::*; #(
  parameter int CHANNELS_PER_BANK = 32,
  parameter int EVENT_BYTES       = 8,
  parameter int COUNTER_WIDTH     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  fdhc_in_if.sink           in_ch,
  fdhc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int NUM_COUNTERS = 2 * CHANNELS_PER_BANK;
  localparam int EPW          = $clog2(EVENT_BYTES);
  localparam int CMPW         = CTR_IDX_W + 1;

  localparam logic [CMPW-1:0] NUM_LIMIT = CMPW'(NUM_COUNTERS);
  localparam logic [EPW-1:0]  EV_LAST   = EPW'(EVENT_BYTES - 1);
  localparam logic [EPW-1:0]  CH_POS    = EPW'(CHANNEL_BYTE);

  // Parser phases
  localparam logic [2:0] PH_ADDR = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CSUM = 3'd4;

  // Register select (paddr bit 2)
  localparam logic REG_OWN_ADDR = 1'b0;
  localparam logic REG_EV_CMD   = 1'b1;

  logic [WORD_W-1:0]    own_addr_r;
  logic [WORD_W-1:0]    ev_cmd_r;

  logic [2:0]           phase_r, phase_nxt;
  logic [WORD_W-1:0]    pos_r, pos_nxt;
  logic [EPW-1:0]       evp_r, evp_nxt;
  logic [BYTE_W-1:0]    ahi_r, ahi_nxt;
  logic [WORD_W-1:0]    cmd_r, cmd_nxt;
  logic [WORD_W-1:0]    len_r, len_nxt;
  logic [BYTE_W-1:0]    evch_r, evch_nxt;
  logic [TALLY_W-1:0]   tally_r, tally_nxt;

  logic                 in_acc, byte_acc, rd_acc, clr_acc;
  logic                 rd_in_range;
  logic                 bump;
  logic [BYTE_W-1:0]    bump_ch;
  logic                 frame_done;
  logic                 is_ev_cmd;
  logic [WORD_W-1:0]    len_full;

  ctr_req_t             req;
  logic [COUNTER_WIDTH-1:0] ctr_value;

  logic                 s1_res_r;
  logic                 s1_kind_r;
  logic [WORD_W-1:0]    s1_cmd_r;
  logic [WORD_W-1:0]    s1_len_r;
  logic [TALLY_W-1:0]   s1_tally_r;
  logic                 s1_hit_r;
  logic                 s1_adv;
  logic                 out_free;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [WORD_W-1:0]    out_cmd_r;
  logic [WORD_W-1:0]    out_len_r;
  logic [HIT_W-1:0]     out_hit_r;
  logic [TALLY_W-1:0]   out_tally_r;

  // Handshake
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_res_r && out_free;
  assign in_ch.ready  = !s1_res_r || out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign byte_acc     = in_acc && (in_ch.action == ACT_BYTE);
  assign rd_acc       = in_acc && (in_ch.action == ACT_READ);
  assign clr_acc      = in_acc && (in_ch.action == ACT_CLEAR);
  assign rd_in_range  = CMPW'(in_ch.channel_index) < NUM_LIMIT;

  // Configuration registers
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      ev_cmd_r   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_OWN_ADDR: own_addr_r <= cfg_pwdata[WORD_W-1:0];
        REG_EV_CMD:   ev_cmd_r   <= cfg_pwdata[WORD_W-1:0];
        default:      own_addr_r <= own_addr_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_OWN_ADDR: cfg_prdata = {16'h0000, own_addr_r};
      REG_EV_CMD:   cfg_prdata = {16'h0000, ev_cmd_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Frame parser
  assign is_ev_cmd = (cmd_r == ev_cmd_r);
  assign len_full  = {len_r[WORD_W-1:BYTE_W], in_ch.data_byte};

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    evp_nxt    = evp_r;
    ahi_nxt    = ahi_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    evch_nxt   = evch_r;
    tally_nxt  = tally_r;
    bump       = 1'b0;
    bump_ch    = evch_r;
    frame_done = 1'b0;
    if (byte_acc) begin
      unique case (phase_r)
        PH_ADDR: begin
          if (pos_r == '0) begin
            ahi_nxt = in_ch.data_byte;
            pos_nxt = WORD_W'(1);
          end else begin
            pos_nxt   = '0;
            phase_nxt = ({ahi_r, in_ch.data_byte} == own_addr_r) ? PH_CMD : PH_ADDR;
          end
        end
        PH_CMD: begin
          if (pos_r == '0) begin
            cmd_nxt = {in_ch.data_byte, 8'h00};
            pos_nxt = WORD_W'(1);
          end else begin
            cmd_nxt   = {cmd_r[WORD_W-1:BYTE_W], in_ch.data_byte};
            pos_nxt   = '0;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (pos_r == '0) begin
            len_nxt = {in_ch.data_byte, 8'h00};
            pos_nxt = WORD_W'(1);
          end else begin
            len_nxt   = len_full;
            pos_nxt   = '0;
            evp_nxt   = '0;
            // empty payload: frame ends here, no checksum
            phase_nxt = (len_full == '0) ? PH_ADDR : PH_DATA;
          end
        end
        PH_DATA: begin
          if (evp_r == CH_POS) begin
            evch_nxt = in_ch.data_byte;
          end
          // last byte of an event in an event frame: count it if the channel is in range (channel byte may be this one)
          if (evp_r == EV_LAST && is_ev_cmd) begin
            bump_ch = (evp_r == CH_POS) ? in_ch.data_byte : evch_r;
            bump    = CMPW'(bump_ch) < NUM_LIMIT;
          end
          evp_nxt = (evp_r == EV_LAST) ? '0 : evp_r + EPW'(1);
          if ({1'b0, pos_r} + 17'd1 >= {1'b0, len_r}) begin
            pos_nxt   = '0;
            phase_nxt = PH_CSUM;
          end else begin
            pos_nxt = pos_r + WORD_W'(1);
          end
        end
        PH_CSUM: begin
          if (pos_r == '0) begin
            pos_nxt = WORD_W'(1);
          end else begin
            pos_nxt   = '0;
            phase_nxt = PH_ADDR;
            if (is_ev_cmd) begin
              tally_nxt = (tally_r == '1) ? tally_r : tally_r + TALLY_W'(1);
            end else begin
              frame_done = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_ADDR;
          pos_nxt   = '0;
        end
      endcase
    end else if (clr_acc) begin
      tally_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      pos_r   <= '0;
      evp_r   <= '0;
      ahi_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      evch_r  <= '0;
      tally_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      evp_r   <= evp_nxt;
      ahi_r   <= ahi_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      evch_r  <= evch_nxt;
      tally_r <= tally_nxt;
    end
  end

  // Counter RAM requests
  always_comb begin
    req.rd_en   = rd_acc && rd_in_range;
    req.bump_en = bump;
    req.clr_en  = clr_acc;
    req.index   = rd_acc ? CTR_IDX_W'(in_ch.channel_index) : bump_ch;
  end

  fdhc_ctr_ram #(
    .NUM (NUM_COUNTERS),
    .CW  (COUNTER_WIDTH)
  ) u_ctr_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_value (ctr_value)
  );

  // RAM stage: result waiting on the counter read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_res_r <= 1'b0;
    end else if (in_acc) begin
      s1_res_r <= frame_done || rd_acc;
    end else if (s1_adv) begin
      s1_res_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (frame_done || rd_acc)) begin
      s1_kind_r  <= rd_acc ? KIND_READ : KIND_FRAME;
      s1_cmd_r   <= rd_acc ? '0 : cmd_r;
      s1_len_r   <= rd_acc ? '0 : len_r;
      s1_tally_r <= tally_r;
      s1_hit_r   <= rd_in_range;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r  <= s1_kind_r;
      out_cmd_r   <= s1_cmd_r;
      out_len_r   <= s1_len_r;
      out_hit_r   <= (s1_kind_r == KIND_READ && s1_hit_r) ? HIT_W'(ctr_value) : '0;
      out_tally_r <= s1_tally_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_kind       = out_kind_r;
  assign out_ch.frame_command     = out_cmd_r;
  assign out_ch.payload_len       = out_len_r;
  assign out_ch.hit_count         = out_hit_r;
  assign out_ch.event_frames_seen = out_tally_r;

  `ASSERT_SAME(a_pos_in_len, phase_r == PH_DATA, pos_r < len_r)
  `ASSERT_SAME(a_pos_small, phase_r != PH_DATA, pos_r <= WORD_W'(1))
  `ASSERT_NEXT(a_tally_sat, tally_r == '1 && !clr_acc, tally_r == '1)
  `ASSERT_SAME(a_stall_full, !in_ch.ready, s1_res_r && out_valid_r)

endmodule
